// ===== rtl/lqi_pkg.sv =====
// Package for the limited quadratic interpolator: transaction structs and constants.
// Depends on nothing; the interpolator unit, checker and testbench files use it by scoped names.
package lqi_pkg;

    localparam int VW = 32;
    localparam int FB = 16;
    localparam logic [15:0] TOL_RESET = 16'd655;

    typedef struct packed {
        logic signed [VW-1:0] left_dx;
        logic signed [VW-1:0] left_dy;
        logic signed [VW-1:0] left_dz;
        logic signed [VW-1:0] right_dx;
        logic signed [VW-1:0] right_dy;
        logic signed [VW-1:0] right_dz;
        logic signed [VW-1:0] target_offset;
        logic signed [VW-1:0] left_value;
        logic signed [VW-1:0] center_value;
        logic signed [VW-1:0] right_value;
    } lqi_in_t;

    typedef struct packed {
        logic signed [VW-1:0] interpolated_value;
        logic                 mesh_error;
    } lqi_out_t;

    // Saturate a wide signed value to the VW-bit signed range.
    function automatic logic signed [VW-1:0] sat_w(input logic signed [127:0] v);
        logic signed [127:0] mx;
        logic signed [127:0] mn;
        mx = 128'sd1 <<< (VW - 1);
        mn = -mx;
        mx = mx - 128'sd1;
        if (v > mx) return mx[VW-1:0];
        if (v < mn) return mn[VW-1:0];
        return v[VW-1:0];
    endfunction

    // Truncating fixed-point product with saturation.
    function automatic logic signed [VW-1:0] q_mul(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b);
        logic [VW-1:0]   ma;
        logic [VW-1:0]   mb;
        logic [2*VW-1:0] p;
        logic [127:0]    m;
        ma = a[VW-1] ? VW'(-a) : VW'(a);
        mb = b[VW-1] ? VW'(-b) : VW'(b);
        p = ma * mb;
        m = 128'(p >> FB);
        return sat_w((a[VW-1] ^ b[VW-1]) ? -$signed(m) : $signed(m));
    endfunction

endpackage

// ===== rtl/lqi_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on nothing.
module lqi_isqrt #(
    parameter int NW = 66,
    parameter int RW = 33,
    parameter int TW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] n,
    input  logic [TW-1:0] tag_in,
    output logic          out_valid,
    output logic [RW-1:0] root,
    output logic [TW-1:0] tag_out
);
    logic [RW:1]   v_reg;
    logic [NW-1:0] n_reg   [1:RW];
    logic [RW-1:0] r_reg   [1:RW];
    logic [TW-1:0] t_reg   [1:RW];

    for (genvar s = 0; s < RW; s++) begin : g_st
        logic            v_in;
        logic [NW-1:0]   n_in;
        logic [RW-1:0]   r_in;
        logic [TW-1:0]   t_in;
        logic [RW-1:0]   cand;
        logic [2*RW-1:0] sq;
        if (s == 0) begin : g_first
            assign v_in = in_valid;
            assign n_in = n;
            assign r_in = '0;
            assign t_in = tag_in;
        end else begin : g_next
            assign v_in = v_reg[s];
            assign n_in = n_reg[s];
            assign r_in = r_reg[s];
            assign t_in = t_reg[s];
        end
        assign cand = r_in | (RW'(1) << (RW - 1 - s));
        assign sq   = cand * cand;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) v_reg[s+1] <= 1'b0;
            else        v_reg[s+1] <= v_in;
        end
        always_ff @(posedge clk)
        begin
            n_reg[s+1] <= n_in;
            t_reg[s+1] <= t_in;
            r_reg[s+1] <= (sq <= n_in) ? cand : r_in;
        end
    end

    assign out_valid = v_reg[RW];
    assign root      = r_reg[RW];
    assign tag_out   = t_reg[RW];
endmodule

// ===== rtl/lqi_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// Depends on nothing.
module lqi_divider #(
    parameter int NW = 80,
    parameter int DW = 70,
    parameter int TW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [TW-1:0] tag_in,
    output logic          out_valid,
    output logic [NW-1:0] quo,
    output logic [TW-1:0] tag_out
);
    logic [NW:1]   v_s;
    logic [NW-1:0] q_s [1:NW];
    logic [DW:0]   r_s [1:NW];
    logic [DW-1:0] d_s [1:NW];
    logic [TW-1:0] t_s [1:NW];

    for (genvar s = 0; s < NW; s++) begin : g_st
        logic          v_in;
        logic [NW-1:0] q_in;
        logic [DW:0]   r_in;
        logic [DW-1:0] d_in;
        logic [TW-1:0] t_in;
        logic [DW+1:0] sh;
        logic          ge;
        if (s == 0) begin : g_first
            assign v_in = in_valid;
            assign q_in = num;
            assign r_in = '0;
            assign d_in = den;
            assign t_in = tag_in;
        end else begin : g_next
            assign v_in = v_s[s];
            assign q_in = q_s[s];
            assign r_in = r_s[s];
            assign d_in = d_s[s];
            assign t_in = t_s[s];
        end
        assign sh = {r_in, q_in[NW-1]};
        assign ge = sh >= {2'b00, d_in};
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) v_s[s+1] <= 1'b0;
            else        v_s[s+1] <= v_in;
        end
        always_ff @(posedge clk)
        begin
            r_s[s+1] <= ge ? (DW+1)'(sh - {2'b00, d_in}) : (DW+1)'(sh);
            q_s[s+1] <= {q_in[NW-2:0], ge};
            d_s[s+1] <= d_in;
            t_s[s+1] <= t_in;
        end
    end

    assign out_valid = v_s[NW];
    assign quo       = q_s[NW];
    assign tag_out   = t_s[NW];
endmodule

// ===== rtl/limited_quadratic_interpolator_unit.sv =====
// Limited quadratic interpolator: fully pipelined, one transaction accepted every cycle.
// The pipeline has 1 input stage, 33 square-root stages, 2 check stages,
// 66 divider stages and 4 evaluation stages; the divider's bit-per-stage chain sets the depth.
// busy is always low, so throughput is one transaction per clock cycle.
// rst_n clears every valid bit and restores tol_reg to 655; data regs are not reset.
// The receiver cannot stall, so done pulses one cycle per result.
module limited_quadratic_interpolator_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lqi_pkg::lqi_in_t  in_data,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_data,
    output logic              done,
    output lqi_pkg::lqi_out_t out_data
);
    localparam int VW = lqi_pkg::VW;
    localparam int FB = lqi_pkg::FB;
    localparam int SW = 2 * VW + 2;      // sum of three squares
    localparam int LW = VW + 1;          // length
    localparam int NW = VW + 2 * FB + 2; // divider numerator width
    localparam int DW = 2 * LW + 2;      // divider denominator width
    // Tag carried alongside the datapath: x, l, c, r values.
    localparam int TW = 4 * VW;

    logic [15:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)      tol_reg <= lqi_pkg::TOL_RESET;
        else if (cfg_we) tol_reg <= cfg_data;
    end

    assign busy = 1'b0;

    // Stage 1: squares of every coordinate difference, summed per neighbor.
    function automatic logic [2*VW-1:0] sq(input logic signed [VW-1:0] v);
        logic [VW-1:0] m;
        m = v[VW-1] ? VW'(-v) : VW'(v);
        return m * m;
    endfunction

    logic          s1_v_reg;
    logic [SW-1:0] s1_sl_reg, s1_sr_reg;
    logic [TW-1:0] s1_t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s1_v_reg <= 1'b0;
        else        s1_v_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        s1_sl_reg <= SW'(sq(in_data.left_dx)) + SW'(sq(in_data.left_dy))
                   + SW'(sq(in_data.left_dz));
        s1_sr_reg <= SW'(sq(in_data.right_dx)) + SW'(sq(in_data.right_dy))
                   + SW'(sq(in_data.right_dz));
        s1_t_reg  <= {in_data.target_offset, in_data.left_value,
                      in_data.center_value, in_data.right_value};
    end

    // Two square-root pipes in lockstep; the right one carries the tag.
    logic          sq_v, sq_vr;
    logic [LW-1:0] len_l, len_r;
    logic [TW-1:0] sq_t;
    logic [0:0]    unused_tag;

    lqi_isqrt #(.NW(SW), .RW(LW), .TW(1)) u_sqrt_l (
        .clk(clk), .rst_n(rst_n), .in_valid(s1_v_reg), .n(s1_sl_reg), .tag_in(1'b0),
        .out_valid(sq_vr), .root(len_l), .tag_out(unused_tag)
    );
    lqi_isqrt #(.NW(SW), .RW(LW), .TW(TW)) u_sqrt_r (
        .clk(clk), .rst_n(rst_n), .in_valid(s1_v_reg), .n(s1_sr_reg), .tag_in(s1_t_reg),
        .out_valid(sq_v), .root(len_r), .tag_out(sq_t)
    );

    // Stage 2: spacing check products and h.
    logic            s2_v_reg;
    logic [LW+17:0]  s2_lhs_reg;
    logic [LW+16:0]  s2_rhs_reg;
    logic [LW-1:0]   s2_h_reg;
    logic [TW-1:0]   s2_t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s2_v_reg <= 1'b0;
        else        s2_v_reg <= sq_v & sq_vr;
    end

    always_ff @(posedge clk)
    begin
        s2_lhs_reg <= (LW+18)'(len_l > len_r ? len_l - len_r : len_r - len_l) << 17;
        s2_rhs_reg <= (LW+17)'(tol_reg) * (LW+17)'({1'b0, len_l} + {1'b0, len_r});
        s2_h_reg   <= LW'(({1'b0, len_l} + {1'b0, len_r}) >> 1);
        s2_t_reg   <= sq_t;
    end

    // Stage 3: error flag, h*h, and differences of the samples.
    logic                  s3_v_reg, s3_err_reg, s3_hz_reg;
    logic [2*LW-1:0]       s3_hh_reg;
    logic [LW-1:0]         s3_h_reg;
    logic signed [VW+2:0]  s3_d1_reg, s3_d2_reg;
    logic [TW-1:0]         s3_t_reg;
    logic signed [VW-1:0]  t_l, t_c, t_r;

    assign t_l = s2_t_reg[3*VW-1:2*VW];
    assign t_c = s2_t_reg[2*VW-1:VW];
    assign t_r = s2_t_reg[VW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s3_v_reg <= 1'b0;
        else        s3_v_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_err_reg <= {1'b0, s2_lhs_reg} > {2'b00, s2_rhs_reg};
        s3_hz_reg  <= s2_h_reg == '0;
        s3_hh_reg  <= s2_h_reg * s2_h_reg;
        s3_h_reg   <= s2_h_reg;
        s3_d1_reg  <= (VW+3)'(t_r) - (VW+3)'(t_l);
        s3_d2_reg  <= (VW+3)'(t_r) - ((VW+3)'(t_c) <<< 1) + (VW+3)'(t_l);
        s3_t_reg   <= s2_t_reg;
    end

    // Two dividers in lockstep: a from d2 and b from d1.
    logic [VW+2:0] m1, m2;
    assign m1 = s3_d1_reg[VW+2] ? (VW+3)'(-s3_d1_reg) : (VW+3)'(s3_d1_reg);
    assign m2 = s3_d2_reg[VW+2] ? (VW+3)'(-s3_d2_reg) : (VW+3)'(s3_d2_reg);

    localparam int XT = TW + 4;
    logic          da_v, db_v;
    logic [NW-1:0] qa, qb;
    logic [XT-1:0] da_t;
    logic [0:0]    db_t;

    lqi_divider #(.NW(NW), .DW(DW), .TW(XT)) u_div_a (
        .clk(clk), .rst_n(rst_n), .in_valid(s3_v_reg),
        .num(NW'(m2) << (2 * FB)),
        .den(s3_hz_reg ? DW'(1) : DW'(s3_hh_reg) << 1),
        .tag_in({s3_t_reg, s3_err_reg, s3_hz_reg, s3_d2_reg[VW+2], s3_d1_reg[VW+2]}),
        .out_valid(da_v), .quo(qa), .tag_out(da_t)
    );
    lqi_divider #(.NW(NW), .DW(DW), .TW(1)) u_div_b (
        .clk(clk), .rst_n(rst_n), .in_valid(s3_v_reg),
        .num(NW'(m1) << FB),
        .den(s3_hz_reg ? DW'(1) : DW'(s3_h_reg) << 1),
        .tag_in(1'b0),
        .out_valid(db_v), .quo(qb), .tag_out(db_t)
    );

    // Evaluation stages.
    logic signed [VW-1:0] e_x, e_l, e_c, e_r;
    assign {e_x, e_l, e_c, e_r} = da_t[XT-1:4];

    logic                 e1_v_reg, e1_err_reg, e1_hz_reg;
    logic signed [VW-1:0] e1_ax_reg, e1_bx_reg;
    logic [TW-1:0]        e1_t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) e1_v_reg <= 1'b0;
        else        e1_v_reg <= da_v & db_v & ~db_t[0] | da_v & db_v;
    end

    always_ff @(posedge clk)
    begin
        e1_ax_reg  <= lqi_pkg::q_mul(lqi_pkg::sat_w(da_t[1] ? -$signed(128'(qa))
                                                            : $signed(128'(qa))), e_x);
        e1_bx_reg  <= lqi_pkg::q_mul(lqi_pkg::sat_w(da_t[0] ? -$signed(128'(qb))
                                                            : $signed(128'(qb))), e_x);
        e1_err_reg <= da_t[3];
        e1_hz_reg  <= da_t[2];
        e1_t_reg   <= da_t[XT-1:4];
    end

    logic signed [VW-1:0] f_x, f_l, f_c, f_r;
    assign {f_x, f_l, f_c, f_r} = e1_t_reg;

    logic                 e2_v_reg, e2_err_reg, e2_hz_reg;
    logic signed [VW-1:0] e2_axx_reg, e2_bx_reg;
    logic [TW-1:0]        e2_t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) e2_v_reg <= 1'b0;
        else        e2_v_reg <= e1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        e2_axx_reg <= lqi_pkg::q_mul(e1_ax_reg, f_x);
        e2_bx_reg  <= e1_bx_reg;
        e2_err_reg <= e1_err_reg;
        e2_hz_reg  <= e1_hz_reg;
        e2_t_reg   <= e1_t_reg;
    end

    logic signed [VW-1:0] g_x, g_l, g_c, g_r;
    assign {g_x, g_l, g_c, g_r} = e2_t_reg;

    logic                 e3_v_reg, e3_err_reg;
    logic signed [VW-1:0] e3_res_reg, e3_hi_reg, e3_lo_reg;
    logic signed [VW-1:0] sum1;
    logic signed [VW-1:0] mx1, mn1;

    assign sum1 = lqi_pkg::sat_w(128'(e2_axx_reg) + 128'(e2_bx_reg));
    assign mx1  = g_r > g_c ? (g_r > g_l ? g_r : g_l) : (g_c > g_l ? g_c : g_l);
    assign mn1  = g_r < g_c ? (g_r < g_l ? g_r : g_l) : (g_c < g_l ? g_c : g_l);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) e3_v_reg <= 1'b0;
        else        e3_v_reg <= e2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        e3_res_reg <= e2_hz_reg ? g_c : lqi_pkg::sat_w(128'(sum1) + 128'(g_c));
        e3_hi_reg  <= mx1;
        e3_lo_reg  <= mn1;
        e3_err_reg <= e2_err_reg;
    end

    // Final stage: limiter and error override.
    logic     o_v_reg;
    lqi_pkg::lqi_out_t o_reg;
    logic signed [VW-1:0] clamped;

    assign clamped = e3_res_reg > e3_hi_reg ? e3_hi_reg
                   : (e3_res_reg < e3_lo_reg ? e3_lo_reg : e3_res_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) o_v_reg <= 1'b0;
        else        o_v_reg <= e3_v_reg;
    end

    always_ff @(posedge clk)
    begin
        o_reg.interpolated_value <= e3_err_reg ? '0 : clamped;
        o_reg.mesh_error         <= e3_err_reg;
    end

    assign done     = o_v_reg;
    assign out_data = o_reg;
endmodule

// ===== rtl/lqi_checker.sv =====
// Port-level checker for the interpolator unit, bound to the top level.
// Depends on lqi_pkg for the output struct.
module lqi_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input lqi_pkg::lqi_out_t out_data
);
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && out_data.mesh_error |-> out_data.interpolated_value == '0)
        else $error("mesh error with nonzero value");
    a_no_done_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !done)
        else $error("result right after reset");
    // Every result follows an accepted transaction by the fixed pipeline latency.
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 106))
        else $error("result without a matching transaction");
endmodule

bind limited_quadratic_interpolator_unit lqi_checker u_lqi_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .out_data(out_data)
);

// ===== tb/sv/lqi_scoreboard.sv =====
// Checker for the limited quadratic interpolator: predicts every result and compares it.
// Depends on lqi_pkg for the transaction structs.
module lqi_scoreboard (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  lqi_pkg::lqi_in_t  in_data,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_data,
    input  logic              done,
    input  lqi_pkg::lqi_out_t out_data,
    output int                pending,
    output int                errors,
    output int                results_seen,
    output int                mesh_errors_seen
);

    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;

    lqi_pkg::lqi_out_t expected_q[$];
    logic [15:0]       tolerance;

    function automatic logic [63:0] magnitude(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [127:0] n);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if ({64'd0, trial} * {64'd0, trial} <= n) root = trial;
        end
        return root;
    endfunction

    function automatic logic [63:0] distance(input logic signed [31:0] x,
                                             input logic signed [31:0] y,
                                             input logic signed [31:0] z);
        logic [127:0] mx, my, mz;
        mx = {64'd0, magnitude(longint'(x))};
        my = {64'd0, magnitude(longint'(y))};
        mz = {64'd0, magnitude(longint'(z))};
        return int_sqrt(mx * mx + my * my + mz * mz);
    endfunction

    // Saturates a magnitude with a sign to the 32-bit signed range.
    function automatic longint clamp_mag(input logic [127:0] m, input bit neg);
        if (m > 128'd2147483647) return neg ? SMIN : SMAX;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic longint clamp_sum(input longint s);
        if (s > SMAX) return SMAX;
        if (s < SMIN) return SMIN;
        return s;
    endfunction

    function automatic longint fixed_mul(input longint a, input longint b);
        logic [127:0] p;
        p = ({64'd0, magnitude(a)} * {64'd0, magnitude(b)}) >> 16;
        return clamp_mag(p, (a < 0) != (b < 0));
    endfunction

    function automatic lqi_pkg::lqi_out_t interpolate(input lqi_pkg::lqi_in_t t,
                                                      input logic [15:0] tol);
        lqi_pkg::lqi_out_t r;
        logic [63:0]  len_l, len_r, gap, h;
        logic [127:0] lhs, rhs;
        longint       x, lv, cv, rv, d1, d2, a, b, est, top, bot;
        len_l = distance(t.left_dx, t.left_dy, t.left_dz);
        len_r = distance(t.right_dx, t.right_dy, t.right_dz);
        x  = longint'(t.target_offset);
        lv = longint'(t.left_value);
        cv = longint'(t.center_value);
        rv = longint'(t.right_value);
        gap = len_l > len_r ? len_l - len_r : len_r - len_l;
        h = (len_l + len_r) >> 1;
        lhs = {64'd0, gap} << 17;
        rhs = {112'd0, tol} * {64'd0, len_l + len_r};
        if (lhs > rhs)
        begin
            r.interpolated_value = '0;
            r.mesh_error = 1'b1;
            return r;
        end
        if (h == 0)
            est = cv;
        else
        begin
            d1 = rv - lv;
            d2 = rv - 2 * cv + lv;
            a = clamp_mag(({64'd0, magnitude(d2)} << 32) /
                          (({64'd0, h} * {64'd0, h}) << 1), d2 < 0);
            b = clamp_mag(({64'd0, magnitude(d1)} << 16) / ({64'd0, h} << 1), d1 < 0);
            est = clamp_sum(clamp_sum(fixed_mul(fixed_mul(a, x), x) + fixed_mul(b, x)) + cv);
        end
        top = rv > cv ? (rv > lv ? rv : lv) : (cv > lv ? cv : lv);
        bot = rv < cv ? (rv < lv ? rv : lv) : (cv < lv ? cv : lv);
        if (est > top) est = top;
        if (est < bot) est = bot;
        r.interpolated_value = est[31:0];
        r.mesh_error = 1'b0;
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        lqi_pkg::lqi_out_t want;
        if (!rst_n)
        begin
            tolerance = lqi_pkg::TOL_RESET;
            expected_q.delete();
            errors = 0;
            results_seen = 0;
            mesh_errors_seen = 0;
        end
        else
        begin
            if (done)
            begin
                results_seen++;
                if (out_data.mesh_error) mesh_errors_seen++;
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Unexpected result: value %0d error %0b",
                                 out_data.interpolated_value, out_data.mesh_error);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.interpolated_value !== out_data.interpolated_value ||
                        want.mesh_error !== out_data.mesh_error)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("Mismatch: expected value %0d error %0b, got value %0d error %0b",
                                     want.interpolated_value, want.mesh_error,
                                     out_data.interpolated_value, out_data.mesh_error);
                    end
                end
            end
            if (start && !busy) expected_q.push_back(interpolate(in_data, tolerance));
            if (cfg_we) tolerance = cfg_data;
        end
    end

endmodule

// ===== tb/sv/limited_quadratic_interpolator_unit_test.sv =====
// Top of the interpolator testbench: clock, reset, stimulus and the final verdict.
// Depends on lqi_pkg, the block itself and the lqi_scoreboard checker.
module limited_quadratic_interpolator_unit_test;

    // The pipeline is 106 stages deep; waits after the last result use a margin on that.
    localparam int DRAIN_CYCLES = 150;
    localparam int CYCLE_LIMIT  = 200000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    lqi_pkg::lqi_in_t  in_data;
    logic              cfg_we;
    logic [15:0]       cfg_data;
    logic              done;
    lqi_pkg::lqi_out_t out_data;

    int pending;
    int errors;
    int results_seen;
    int mesh_errors_seen;
    int items_sent;
    bit no_gaps;

    limited_quadratic_interpolator_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .in_data  (in_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .done     (done),
        .out_data (out_data)
    );

    lqi_scoreboard checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .in_data          (in_data),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .done             (done),
        .out_data         (out_data),
        .pending          (pending),
        .errors           (errors),
        .results_seen     (results_seen),
        .mesh_errors_seen (mesh_errors_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung pipeline or a lost result ends the run here.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles with %0d results outstanding", CYCLE_LIMIT, pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Signed random value confined to roughly +/- 2^bits.
    function automatic logic signed [31:0] rand_span(input int bits);
        return $signed($urandom) >>> (31 - bits);
    endfunction

    // Offers one transaction from a falling edge and holds it until an edge accepts it.
    // busy is tied low, so its value at the falling edge holds through the next rising edge.
    task automatic send(input lqi_pkg::lqi_in_t t);
        bit was_busy;
        start = 1'b1;
        in_data = t;
        do
        begin
            was_busy = busy;
            @(negedge clk);
        end while (was_busy);
        items_sent++;
        // The sender leaves a gap with start low about 21 times in a hundred unless a quiet stretch is on.
        if (!no_gaps && $urandom_range(0, 99) < 21)
        begin
            start = 1'b0;
            in_data = '{default: '0};
            @(negedge clk);
        end
    endtask

    // Lets the pipeline empty completely, then idles past its depth.
    task automatic drain();
        start = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_tolerance(input logic [15:0] v);
        drain();
        cfg_we = 1'b1;
        cfg_data = v;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Mostly well-formed stencils: the right neighbor mirrors the left one, sometimes with
    // a small jitter that the tolerance may or may not absorb. The rest is unconstrained.
    task automatic random_items(input int count);
        lqi_pkg::lqi_in_t t;
        int bits;
        int kind;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 99);
            bits = $urandom_range(2, 30);
            t.left_dx = rand_span(bits);
            t.left_dy = ($urandom_range(0, 2) == 0) ? rand_span(bits) : 32'sd0;
            t.left_dz = ($urandom_range(0, 3) == 0) ? rand_span(bits) : 32'sd0;
            t.right_dx = -t.left_dx;
            t.right_dy = -t.left_dy;
            t.right_dz = -t.left_dz;
            if (kind < 35)
                t.right_dx = t.right_dx + rand_span($urandom_range(0, bits));
            t.target_offset = rand_span(bits);
            if ($urandom_range(0, 2) == 0)
            begin
                t.left_value   = $urandom;
                t.center_value = $urandom;
                t.right_value  = $urandom;
            end
            else
            begin
                bits = $urandom_range(4, 26);
                t.left_value   = rand_span(bits);
                t.center_value = rand_span(bits);
                t.right_value  = rand_span(bits);
            end
            if (kind >= 80)
                t = {$urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom};
            send(t);
        end
    endtask

    // Hand-picked cases: zero spacing, extreme coordinates and values, non-uniform grids,
    // saturating curvature and slope, and targets on either side of the center.
    task automatic directed_items();
        lqi_pkg::lqi_in_t t;
        t = '{default: '0};
        send(t);
        t.center_value = 32'sh7FFF_FFFF;
        t.left_value = 32'sh8000_0000;
        send(t);
        t = '{default: '0};
        t.left_dx = 32'sh8000_0000;
        t.left_dy = 32'sh8000_0000;
        t.left_dz = 32'sh8000_0000;
        t.right_dx = 32'sh8000_0000;
        t.right_dy = 32'sh8000_0000;
        t.right_dz = 32'sh8000_0000;
        t.target_offset = 32'sh7FFF_FFFF;
        t.left_value = 32'sh7FFF_FFFF;
        t.center_value = 32'sh8000_0000;
        t.right_value = 32'sh7FFF_FFFF;
        send(t);
        t.right_dx = 32'sh7FFF_FFFF;
        t.right_dy = 32'sh7FFF_FFFF;
        t.right_dz = 32'sh7FFF_FFFF;
        t.target_offset = 32'sh8000_0000;
        send(t);
        t = '{default: '0};
        t.left_dx = -32'sh0001_0000;
        t.right_dx = 32'sh0001_0000;
        t.left_value = 32'sh0001_0000;
        t.center_value = 32'sh0002_0000;
        t.right_value = 32'sh0005_0000;
        for (int k = -2; k <= 2; k++)
        begin
            t.target_offset = k * 32'sh0000_8000;
            send(t);
        end
        t.target_offset = 32'sh7FFF_FFFF;
        send(t);
        t.target_offset = 32'sh8000_0000;
        send(t);
        // Tiny spacing with large value jumps drives the curvature and slope into saturation.
        t.left_dx = -32'sd1;
        t.right_dx = 32'sd1;
        t.left_value = 32'sh8000_0000;
        t.center_value = 32'sh7FFF_FFFF;
        t.right_value = 32'sh8000_0000;
        t.target_offset = 32'sd1;
        send(t);
        t.center_value = 32'sh0;
        t.right_value = 32'sh7FFF_FFFF;
        send(t);
        // One neighbor at the center, the other away: a clear mesh error.
        t.left_dx = 32'sd0;
        t.right_dx = 32'sh0010_0000;
        send(t);
        // Spacing mismatch just around the default tolerance of about one percent.
        t.left_dx = -32'sh0064_0000;
        t.right_dx = 32'sh0065_0000;
        send(t);
        t.right_dx = 32'sh0064_8000;
        send(t);
        t.left_dy = 32'sh0030_0000;
        t.right_dy = -32'sh0030_0000;
        t.right_dz = 32'sh0000_0001;
        send(t);
        t.right_value = 32'sh8000_0000;
        t.left_value = 32'sh7FFF_FFFF;
        t.target_offset = -32'sh0064_0000;
        send(t);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        in_data = '{default: '0};
        cfg_we = 1'b0;
        cfg_data = '0;
        items_sent = 0;
        no_gaps = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset tolerance first, then the extremes and two values in between.
        directed_items();
        random_items(250);
        write_tolerance(16'd0);
        directed_items();
        random_items(200);
        // Hold off until the pipeline has handed back every pending result, then resume.
        start = 1'b0;
        while (pending != 0) @(negedge clk);
        random_items(100);
        write_tolerance(16'hFFFF);
        directed_items();
        no_gaps = 1'b1;
        random_items(300);
        no_gaps = 1'b0;
        write_tolerance(16'($urandom_range(1, 65534)));
        random_items(300);
        write_tolerance(lqi_pkg::TOL_RESET);
        random_items(300);

        drain();
        $display("Covered %0d transactions under five tolerance settings, %0d mesh errors seen.",
                 items_sent, mesh_errors_seen);
        $display("Compared %0d results; %0d mismatches found.", results_seen, errors);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
